// ----- rtl/core/ssu_pkg.sv -----
`timescale 1ns / 1ps
// ssu_pkg: shared widths, limits and codes of the smoothstep wrap upscaler
// used by ssu_div and smoothstep_wrap_upscale; no dependencies
package ssu_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_SCALE  = 256;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

	localparam int DIM_W   = 7;
	localparam int SCALE_W = 9;
	localparam int OFF_W   = $clog2(MAX_SCALE);
	localparam int PIX_W   = 14;
	localparam int SMP_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int DIV_W   = FRAC_W + OFF_W;
	localparam int CNT_W   = $clog2(DIV_W + 1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef enum logic [1:0] {
		CFG_MAP_WIDTH   = 2'd0,
		CFG_MAP_HEIGHT  = 2'd1,
		CFG_HORIZ_SCALE = 2'd2,
		CFG_VERT_SCALE  = 2'd3
	} cfg_idx_t;

endpackage

// ----- rtl/core/ssu_div.sv -----
`timescale 1ns / 1ps
// ssu_div: radix-2 restoring divider, one quotient bit per cycle
// depends on ssu_pkg
module ssu_div import ssu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	input  logic [SCALE_W-1:0] divisor,
	output logic               done,
	output logic [DIV_W-1:0]   quotient,
	output logic [SCALE_W-1:0] remainder
);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [DIV_W-1:0]   quo_q;
	logic [SCALE_W-1:0] rem_q;
	logic [SCALE_W-1:0] dvs_q;

	logic [SCALE_W:0]   shifted;
	logic [SCALE_W:0]   trial;
	logic               fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/smoothstep_wrap_upscale.sv -----
`timescale 1ns / 1ps
// smoothstep_wrap_upscale: top level, source map memory, sequencer and datapath
// depends on ssu_pkg and ssu_div
//
//  channel   handshake              payload
//  ------------------------------------------------------------------------
//  request   start / busy           req_type src_col src_row sample pix_x pix_y
//  result    done (one-cycle)       pixel range_error
//  config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// a write is stored when it is accepted and never raises busy; a read outside the
// image answers on the next cycle and leaves busy low. an in-range read holds busy
// until done rises, which is in the cycle that busy falls: four runs of the 24-step
// divider (cell and offset in x, then in y, then the two weights), the weight steps
// S_WT1 and S_WT2, four map reads on the single read port, three S_BDIFF-S_BMUL-S_BADD blends.
// reset loads the register defaults; the map is not cleared.
// results cannot be stalled; done is high for exactly one cycle.
module smoothstep_wrap_upscale import ssu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [COL_W-1:0]   src_col,
	input  logic [ROW_W-1:0]   src_row,
	input  logic [SMP_W-1:0]   sample,
	input  logic [PIX_W-1:0]   pix_x,
	input  logic [PIX_W-1:0]   pix_y,
	output logic               done,
	output logic [SMP_W-1:0]   pixel,
	output logic               range_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [SCALE_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WT1,
		S_WT2,
		S_FETCH,
		S_BDIFF,
		S_BMUL,
		S_BADD
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]   map_width_q, map_height_q;
	logic [SCALE_W-1:0] horiz_scale_q, vert_scale_q;
	logic [DIM_W-1:0]   w_c, h_c;
	logic [SCALE_W-1:0] hs_c, vs_c;

	logic accept, rd_accept, wr_en, out_of_range;
	logic [DIM_W+SCALE_W-1:0] lim_x, lim_y;

	logic [SMP_W-1:0] mem [DEPTH];
	logic [SMP_W-1:0] rdata_q;
	logic [ADDR_W-1:0] rd_addr;
	logic rd_en;

	logic [PIX_W-1:0] px_q, py_q;
	logic [COL_W-1:0] cx_q, nx;
	logic [ROW_W-1:0] cy_q, ny;
	logic [OFF_W-1:0] offx_q, offy_q;
	logic [FRAC_W-1:0] tx_q, ty_q;
	logic [FRAC_W-1:0] t2x_q, t2y_q;
	logic [FRAC_W+1:0] polyx_q, polyy_q;
	logic [FRAC_W-1:0] wx_q, wy_q;
	logic [2*FRAC_W-1:0] sqx, sqy;
	logic [2*FRAC_W+1:0] wtx, wty;

	logic [1:0] div_sel_q;
	logic div_start_q, div_done;
	logic [DIV_W-1:0] div_dividend, div_quo;
	logic [SCALE_W-1:0] div_divisor, div_rem;

	logic [2:0] fcnt_q;
	logic [1:0] fcnt_m1;
	logic [SMP_W-1:0] samp_q [4];

	logic [1:0] bsel_q;
	logic [SMP_W-1:0] bl_a, bl_b, bl_w;
	logic [SMP_W-1:0] diff_s1, base_s1, wgt_s1;
	logic neg_s1;
	logic [2*SMP_W-1:0] prod_s2;
	logic [SMP_W-1:0] base_s2;
	logic neg_s2;
	logic [SMP_W-1:0] bl_res;
	logic [SMP_W-1:0] top_q, bot_q;

	logic done_q, range_error_q;
	logic [SMP_W-1:0] pixel_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= DIM_W'(MAX_WIDTH);
			map_height_q  <= DIM_W'(MAX_HEIGHT);
			horiz_scale_q <= SCALE_W'(1);
			vert_scale_q  <= SCALE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_WIDTH:   map_width_q   <= cfg_data[DIM_W-1:0];
				CFG_MAP_HEIGHT:  map_height_q  <= cfg_data[DIM_W-1:0];
				CFG_HORIZ_SCALE: horiz_scale_q <= cfg_data;
				CFG_VERT_SCALE:  vert_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_c  = (map_width_q == '0) ? DIM_W'(1) :
		(map_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width_q;
	assign h_c  = (map_height_q == '0) ? DIM_W'(1) :
		(map_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height_q;
	assign hs_c = (horiz_scale_q == '0) ? SCALE_W'(1) :
		(horiz_scale_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : horiz_scale_q;
	assign vs_c = (vert_scale_q == '0) ? SCALE_W'(1) :
		(vert_scale_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : vert_scale_q;

	// request decode
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign wr_en     = accept && (req_type == REQ_WRITE);
	assign rd_accept = accept && (req_type == REQ_READ);

	assign lim_x = (DIM_W+SCALE_W)'(w_c) * (DIM_W+SCALE_W)'(hs_c);
	assign lim_y = (DIM_W+SCALE_W)'(h_c) * (DIM_W+SCALE_W)'(vs_c);
	assign out_of_range = ((DIM_W+SCALE_W)'(pix_x) >= lim_x) ||
		((DIM_W+SCALE_W)'(pix_y) >= lim_y);

	// source map
	always_comb begin
		case (fcnt_q[1:0])
			2'd0:    rd_addr = {cy_q, cx_q};
			2'd1:    rd_addr = {cy_q, nx};
			2'd2:    rd_addr = {ny, cx_q};
			default: rd_addr = {ny, nx};
		endcase
	end

	assign rd_en = (state_q == S_FETCH) && !fcnt_q[2];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[{src_row, src_col}] <= sample;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// wrap to column or row 0 past the last one in use
	assign nx = ((DIM_W'(cx_q) + DIM_W'(1)) == w_c) ? '0 : cx_q + COL_W'(1);
	assign ny = ((DIM_W'(cy_q) + DIM_W'(1)) == h_c) ? '0 : cy_q + ROW_W'(1);

	// divider operands: cell x, cell y, weight x, weight y
	always_comb begin
		case (div_sel_q)
			2'd0: begin
				div_dividend = DIV_W'(px_q);
				div_divisor  = hs_c;
			end
			2'd1: begin
				div_dividend = DIV_W'(py_q);
				div_divisor  = vs_c;
			end
			2'd2: begin
				div_dividend = {offx_q, {FRAC_W{1'b0}}};
				div_divisor  = hs_c;
			end
			default: begin
				div_dividend = {offy_q, {FRAC_W{1'b0}}};
				div_divisor  = vs_c;
			end
		endcase
	end

	ssu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// smoothstep weights
	assign sqx = tx_q * tx_q;
	assign sqy = ty_q * ty_q;
	assign wtx = (2*FRAC_W+2)'(t2x_q) * (2*FRAC_W+2)'(polyx_q);
	assign wty = (2*FRAC_W+2)'(t2y_q) * (2*FRAC_W+2)'(polyy_q);

	// blend operands: top row, bottom row, then vertical
	always_comb begin
		case (bsel_q)
			2'd0: begin
				bl_a = samp_q[0];
				bl_b = samp_q[1];
				bl_w = wx_q;
			end
			2'd1: begin
				bl_a = samp_q[2];
				bl_b = samp_q[3];
				bl_w = wx_q;
			end
			default: begin
				bl_a = top_q;
				bl_b = bot_q;
				bl_w = wy_q;
			end
		endcase
	end

	assign bl_res  = neg_s2 ? base_s2 - prod_s2[2*SMP_W-1:SMP_W] :
		base_s2 + prod_s2[2*SMP_W-1:SMP_W];
	assign fcnt_m1 = 2'(fcnt_q - 3'd1);

	// datapath
	always_ff @(posedge clk) begin
		if (rd_accept) begin
			px_q <= pix_x;
			py_q <= pix_y;
		end
		if (state_q == S_DIV && div_done) begin
			case (div_sel_q)
				2'd0: begin
					cx_q   <= div_quo[COL_W-1:0];
					offx_q <= div_rem[OFF_W-1:0];
				end
				2'd1: begin
					cy_q   <= div_quo[ROW_W-1:0];
					offy_q <= div_rem[OFF_W-1:0];
				end
				2'd2:    tx_q <= div_quo[FRAC_W-1:0];
				default: ty_q <= div_quo[FRAC_W-1:0];
			endcase
		end
		if (state_q == S_WT1) begin
			t2x_q   <= sqx[2*FRAC_W-1:FRAC_W];
			t2y_q   <= sqy[2*FRAC_W-1:FRAC_W];
			polyx_q <= (FRAC_W+2)'(3 << FRAC_W) - {1'b0, tx_q, 1'b0};
			polyy_q <= (FRAC_W+2)'(3 << FRAC_W) - {1'b0, ty_q, 1'b0};
		end
		if (state_q == S_WT2) begin
			wx_q <= wtx[2*FRAC_W-1:FRAC_W];
			wy_q <= wty[2*FRAC_W-1:FRAC_W];
		end
		if (state_q == S_FETCH && fcnt_q != '0)
			samp_q[fcnt_m1] <= rdata_q;
		if (state_q == S_BDIFF) begin
			neg_s1  <= bl_b < bl_a;
			diff_s1 <= (bl_b < bl_a) ? bl_a - bl_b : bl_b - bl_a;
			base_s1 <= bl_a;
			wgt_s1  <= bl_w;
		end
		if (state_q == S_BMUL) begin
			prod_s2 <= diff_s1 * wgt_s1;
			base_s2 <= base_s1;
			neg_s2  <= neg_s1;
		end
		if (state_q == S_BADD) begin
			case (bsel_q)
				2'd0:    top_q <= bl_res;
				2'd1:    bot_q <= bl_res;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			div_sel_q     <= '0;
			div_start_q   <= 1'b0;
			fcnt_q        <= '0;
			bsel_q        <= '0;
			done_q        <= 1'b0;
			pixel_q       <= '0;
			range_error_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (rd_accept) begin
						if (out_of_range) begin
							done_q        <= 1'b1;
							pixel_q       <= '0;
							range_error_q <= 1'b1;
						end else begin
							div_sel_q   <= '0;
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_sel_q == 2'd3) begin
							state_q <= S_WT1;
						end else begin
							div_sel_q   <= div_sel_q + 2'd1;
							div_start_q <= 1'b1;
						end
					end
				end
				S_WT1: state_q <= S_WT2;
				S_WT2: begin
					fcnt_q  <= '0;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (fcnt_q == 3'd4) begin
						bsel_q  <= '0;
						state_q <= S_BDIFF;
					end else begin
						fcnt_q <= fcnt_q + 3'd1;
					end
				end
				S_BDIFF: state_q <= S_BMUL;
				S_BMUL:  state_q <= S_BADD;
				S_BADD: begin
					if (bsel_q == 2'd2) begin
						done_q        <= 1'b1;
						pixel_q       <= bl_res;
						range_error_q <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						bsel_q  <= bsel_q + 2'd1;
						state_q <= S_BDIFF;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign pixel       = pixel_q;
	assign range_error = range_error_q;

endmodule

// ----- test/tb_smoothstep_wrap_upscale.sv -----
`timescale 1ns / 1ps
// tb_smoothstep_wrap_upscale: self-checking bench for the smoothstep wrap upscaler
// directed stimulus table, then random phases over register settings, checked by a local
// predictor of the interpolation; depends on ssu_pkg and smoothstep_wrap_upscale
module tb_smoothstep_wrap_upscale;
	import ssu_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 130;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 65;
	localparam int PRESSURE_AT    = 30;

	typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [SMP_W-1:0] pixel;
		logic             range_error;
	} pixel_result_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_idx_t           reg_sel;
		logic [SCALE_W-1:0] reg_val;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [SMP_W-1:0]   smp;
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic               typed;
		pixel_result_t      want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic [COL_W-1:0]   src_col;
	logic [ROW_W-1:0]   src_row;
	logic [SMP_W-1:0]   sample;
	logic [PIX_W-1:0]   pix_x;
	logic [PIX_W-1:0]   pix_y;
	logic               done;
	logic [SMP_W-1:0]   pixel;
	logic               range_error;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [SCALE_W-1:0] cfg_data;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SCALE_W-1:0] hscale_q;
	logic [SCALE_W-1:0] vscale_q;
	logic [SMP_W-1:0]   map_shadow [DEPTH];
	bit                 map_valid [DEPTH];

	pixel_result_t pending_pixels [$];
	pixel_result_t got_want;
	stim_row_t     directed_rows [26];

	int unsigned mismatches;
	int unsigned stall_cycles;
	int unsigned items_sent;
	int unsigned writes_sent;
	int unsigned reads_sent;
	int unsigned oob_reads;
	int unsigned reg_writes;
	int unsigned settings_used;
	int unsigned idle_pct;

	smoothstep_wrap_upscale uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.src_col     (src_col),
		.src_row     (src_row),
		.sample      (sample),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.done        (done),
		.pixel       (pixel),
		.range_error (range_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned held(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : (v > hi) ? hi : v;
	endfunction

	function automatic int unsigned ease_weight(input int unsigned off, input int unsigned scale);
		bit [63:0] t;
		bit [63:0] t2;
		t  = (64'(off) << FRAC_W) / 64'(scale);
		t2 = (t * t) >> FRAC_W;
		return 32'((t2 * ((64'd3 << FRAC_W) - (t << 1))) >> FRAC_W);
	endfunction

	function automatic int unsigned mix(input int unsigned a, input int unsigned b,
			input int unsigned wgt);
		bit [63:0] span;
		span = (b >= a) ? 64'(b - a) : 64'(a - b);
		span = (span * 64'(wgt)) >> FRAC_W;
		return (b >= a) ? a + span[31:0] : a - span[31:0];
	endfunction

	// cell and wrapped neighbor of a pixel under the current settings
	function automatic bit locate(input int unsigned px, input int unsigned py,
			output int unsigned cx, output int unsigned cy,
			output int unsigned nx, output int unsigned ny);
		int unsigned w;
		int unsigned h;
		int unsigned hs;
		int unsigned vs;
		w  = held(width_q, MAX_WIDTH);
		h  = held(height_q, MAX_HEIGHT);
		hs = held(hscale_q, MAX_SCALE);
		vs = held(vscale_q, MAX_SCALE);
		cx = px / hs;
		cy = py / vs;
		nx = (cx + 1 == w) ? 0 : cx + 1;
		ny = (cy + 1 == h) ? 0 : cy + 1;
		return (px < w * hs) && (py < h * vs);
	endfunction

	function automatic pixel_result_t predict_pixel(input int unsigned px, input int unsigned py);
		int unsigned cx;
		int unsigned cy;
		int unsigned nx;
		int unsigned ny;
		int unsigned hs;
		int unsigned vs;
		int unsigned sx;
		int unsigned sy;
		int unsigned top;
		int unsigned bot;
		pixel_result_t res;
		if (!locate(px, py, cx, cy, nx, ny)) begin
			res.pixel = '0;
			res.range_error = 1'b1;
			return res;
		end
		hs  = held(hscale_q, MAX_SCALE);
		vs  = held(vscale_q, MAX_SCALE);
		sx  = ease_weight(px - cx * hs, hs);
		sy  = ease_weight(py - cy * vs, vs);
		top = mix(map_shadow[cy * MAX_WIDTH + cx], map_shadow[cy * MAX_WIDTH + nx], sx);
		bot = mix(map_shadow[ny * MAX_WIDTH + cx], map_shadow[ny * MAX_WIDTH + nx], sx);
		res.pixel = SMP_W'(mix(top, bot, sy));
		res.range_error = 1'b0;
		return res;
	endfunction

	function automatic logic [SMP_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// mostly inside the image, biased to cell borders; cell_no == dim lands just past the edge
	function automatic int unsigned pick_coord(input int unsigned dim, input int unsigned scale);
		int unsigned cell_no;
		int unsigned off;
		cell_no = $urandom_range(0, dim);
		case ($urandom_range(0, 3))
			0: off = 0;
			1: off = scale - 1;
			default: off = $urandom_range(0, scale - 1);
		endcase
		return (cell_no * scale + off) % (1 << PIX_W);
	endfunction

	task automatic send_item(input stim_row_t item);
		pixel_result_t want;
		start    <= 1'b1;
		req_type <= (item.kind == ROW_READ) ? REQ_READ : REQ_WRITE;
		src_col  <= item.col;
		src_row  <= item.row;
		sample   <= item.smp;
		pix_x    <= item.px;
		pix_y    <= item.py;
		do @(posedge clk); while (busy);
		items_sent++;
		if (item.kind == ROW_WRITE) begin
			map_shadow[{item.row, item.col}] = item.smp;
			map_valid[{item.row, item.col}] = 1'b1;
			writes_sent++;
		end else begin
			want = item.typed ? item.want : predict_pixel(item.px, item.py);
			pending_pixels.push_back(want);
			reads_sent++;
			if (want.range_error)
				oob_reads++;
		end
	endtask

	task automatic sender_gap();
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t sel, input logic [SCALE_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (sel)
			CFG_MAP_WIDTH:   width_q  = val[DIM_W-1:0];
			CFG_MAP_HEIGHT:  height_q = val[DIM_W-1:0];
			CFG_HORIZ_SCALE: hscale_q = val;
			CFG_VERT_SCALE:  vscale_q = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// fill any unwritten neighbor first so no read touches an empty entry
	task automatic read_pixel(input int unsigned px, input int unsigned py);
		int unsigned cx;
		int unsigned cy;
		int unsigned nx;
		int unsigned ny;
		int unsigned cells [4];
		stim_row_t item;
		px = px % (1 << PIX_W);
		py = py % (1 << PIX_W);
		item = '0;
		if (locate(px, py, cx, cy, nx, ny)) begin
			cells = '{cy * MAX_WIDTH + cx, cy * MAX_WIDTH + nx,
				ny * MAX_WIDTH + cx, ny * MAX_WIDTH + nx};
			foreach (cells[k]) begin
				if (!map_valid[cells[k]]) begin
					item.kind = ROW_WRITE;
					item.col  = COL_W'(cells[k] % MAX_WIDTH);
					item.row  = ROW_W'(cells[k] / MAX_WIDTH);
					item.smp  = random_sample();
					send_item(item);
					sender_gap();
				end
			end
		end
		item = '0;
		item.kind = ROW_READ;
		item.px   = PIX_W'(px);
		item.py   = PIX_W'(py);
		send_item(item);
		sender_gap();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pixel %h range_error %b", pixel, range_error);
			end else begin
				got_want = pending_pixels.pop_front();
				if (pixel !== got_want.pixel || range_error !== got_want.range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pixel %h range_error %b, got pixel %h range_error %b",
							got_want.pixel, got_want.range_error, pixel, range_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", stall_cycles);
			$display("smoothstep_wrap_upscale verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned pw;
		int unsigned ph;
		int unsigned phs;
		int unsigned pvs;
		int unsigned phase_base;
		bit          paused;
		stim_row_t   item;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		req_type  <= REQ_WRITE;
		src_col   <= '0;
		src_row   <= '0;
		sample    <= '0;
		pix_x     <= '0;
		pix_y     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MAP_WIDTH;
		cfg_data  <= '0;
		width_q   = 7'd64;
		height_q  = 7'd64;
		hscale_q  = 9'd1;
		vscale_q  = 9'd1;

		// kind, register, value, col, row, sample, x, y, typed, expected
		directed_rows = '{
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'hFFFF, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd1, 6'd0, 16'h0000, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd1, 16'h8000, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd1, 6'd1, 16'h0001, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b1,
				{16'hFFFF, 1'b0}},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd64, 14'd0, 1'b1,
				{16'h0000, 1'b1}},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd64, 1'b1,
				{16'h0000, 1'b1}},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd16383, 14'd16383, 1'b1,
				{16'h0000, 1'b1}},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd63, 6'd63, 16'h1357, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd63, 16'hFFFF, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_WRITE, CFG_MAP_WIDTH, 9'd0, 6'd63, 6'd0, 16'h0000, 14'd0, 14'd0, 1'b0, 17'd0},
			// wraps to column 0 and row 0
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd63, 14'd63, 1'b1,
				{16'h1357, 1'b0}},
			'{ROW_CFG, CFG_MAP_WIDTH, 9'd2, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_CFG, CFG_MAP_HEIGHT, 9'd2, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_CFG, CFG_HORIZ_SCALE, 9'd256, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			// saturates to the largest scale
			'{ROW_CFG, CFG_VERT_SCALE, 9'd511, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd128, 14'd128, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd255, 14'd0, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd255, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd511, 14'd511, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd512, 14'd0, 1'b1,
				{16'h0000, 1'b1}},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd512, 1'b1,
				{16'h0000, 1'b1}},
			// zero scale counts as one
			'{ROW_CFG, CFG_HORIZ_SCALE, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_CFG, CFG_VERT_SCALE, 9'd0, 6'd0, 6'd0, 16'h0, 14'd0, 14'd0, 1'b0, 17'd0},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd1, 14'd1, 1'b1,
				{16'h0001, 1'b0}},
			'{ROW_READ, CFG_MAP_WIDTH, 9'd0, 6'd0, 6'd0, 16'h0, 14'd2, 14'd0, 1'b1,
				{16'h0000, 1'b1}}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 9;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_register(directed_rows[i].reg_sel, directed_rows[i].reg_val);
			end else begin
				send_item(directed_rows[i]);
				sender_gap();
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					pw = 64; ph = 64; phs = 256; pvs = 256;
				end
				1: begin
					pw = 1; ph = 1; phs = 1; pvs = 1;
				end
				2: begin
					pw = 0; ph = 127; phs = 0; pvs = 511;
				end
				3: begin
					pw  = $urandom_range(1, 8);
					ph  = $urandom_range(1, 8);
					phs = $urandom_range(1, 300);
					pvs = $urandom_range(1, 300);
				end
				default: begin
					pw  = $urandom_range(0, 127);
					ph  = $urandom_range(0, 127);
					phs = $urandom_range(0, 511);
					pvs = $urandom_range(0, 511);
				end
			endcase
			idle_pct = (phase < 2) ? 9 : (phase < 4) ? 51 : 0;
			write_register(CFG_MAP_WIDTH, SCALE_W'(pw));
			write_register(CFG_MAP_HEIGHT, SCALE_W'(ph));
			write_register(CFG_HORIZ_SCALE, SCALE_W'(phs));
			write_register(CFG_VERT_SCALE, SCALE_W'(pvs));
			settings_used++;

			phase_base = items_sent;
			paused = 1'b0;
			while (items_sent - phase_base < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						item      = '0;
						item.kind = ROW_WRITE;
						item.col  = COL_W'($urandom);
						item.row  = ROW_W'($urandom);
						item.smp  = random_sample();
						send_item(item);
						sender_gap();
					end
					2: read_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
					default: read_pixel(pick_coord(held(width_q, MAX_WIDTH), held(hscale_q, MAX_SCALE)),
						pick_coord(held(height_q, MAX_HEIGHT), held(vscale_q, MAX_SCALE)));
				endcase
				if (!paused && items_sent - phase_base >= PRESSURE_AT) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d sample writes and %0d pixel reads (%0d outside the image)",
			writes_sent, reads_sent, oob_reads);
		$display("over %0d register writes in %0d random settings; %0d mismatches",
			reg_writes, settings_used, mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("smoothstep_wrap_upscale verification clean");
		else
			$display("smoothstep_wrap_upscale verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ssu_pkg.sv
rtl/core/ssu_div.sv
rtl/core/smoothstep_wrap_upscale.sv
test/tb_smoothstep_wrap_upscale.sv
